[rtl/core/rc4ks_pkg.sv]
package rc4ks_pkg;

    localparam int KEY_WORD_W = 64;
    localparam int KEY_LEN_W  = 5;
    localparam int BYTE_W     = 8;
    localparam int LANES      = 8;
    localparam int LANE_W     = 3;
    localparam int ROWS       = 32;
    localparam int ROW_W      = 5;
    localparam int IDX_W      = 8;
    localparam int ROW_DATA_W = LANES * BYTE_W;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FILL,
        OP_RD_I,
        OP_RD_J,
        OP_WR_J,
        OP_WR_I,
        OP_OUT_RD,
        OP_OUT_LD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic chunk_last;  // row counter at the final row
        logic pass_last;   // swap pass counter at the final pass
        logic out_free;    // output register can take a word this cycle
    } t_dp_sts;

endpackage

[rtl/core/rc4ks_if.sv]
interface rc4ks_key_if;
    logic                                  valid;
    logic                                  ready;
    logic [rc4ks_pkg::KEY_WORD_W-1:0]      key_bytes_low;
    logic [rc4ks_pkg::KEY_WORD_W-1:0]      key_bytes_high;
    logic [rc4ks_pkg::KEY_LEN_W-1:0]       key_length;

    modport source (output valid, key_bytes_low, key_bytes_high, key_length, input ready);
    modport sink   (input valid, key_bytes_low, key_bytes_high, key_length, output ready);
endinterface

interface rc4ks_perm_if;
    logic                                  valid;
    logic                                  ready;
    logic [rc4ks_pkg::ROW_W-1:0]           chunk_index;
    logic [rc4ks_pkg::ROW_DATA_W-1:0]      perm_bytes;
    logic                                  last_chunk;

    modport source (output valid, chunk_index, perm_bytes, last_chunk, input ready);
    modport sink   (input valid, chunk_index, perm_bytes, last_chunk, output ready);
endinterface

[rtl/core/rc4ks_ctrl.sv]
module rc4ks_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  rc4ks_pkg::t_dp_sts i_sts,
    output logic               o_in_ready,
    output rc4ks_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_RD_I,
        S_RD_J,
        S_WR_J,
        S_WR_I,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = rc4ks_pkg::OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = rc4ks_pkg::OP_LOAD;
                    n_state  = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.op = rc4ks_pkg::OP_FILL;
                if (i_sts.chunk_last) begin
                    n_state = S_RD_I;
                end
            end
            S_RD_I: begin
                o_cmd.op = rc4ks_pkg::OP_RD_I;
                n_state  = S_RD_J;
            end
            S_RD_J: begin
                o_cmd.op = rc4ks_pkg::OP_RD_J;
                n_state  = S_WR_J;
            end
            S_WR_J: begin
                o_cmd.op = rc4ks_pkg::OP_WR_J;
                n_state  = S_WR_I;
            end
            S_WR_I: begin
                o_cmd.op = rc4ks_pkg::OP_WR_I;
                n_state  = i_sts.pass_last ? S_OUT_RD : S_RD_I;
            end
            S_OUT_RD: begin
                o_cmd.op = rc4ks_pkg::OP_OUT_RD;
                n_state  = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.op = rc4ks_pkg::OP_OUT_LD;
                    n_state  = i_sts.chunk_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/rc4ks_dp.sv]
module rc4ks_dp #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rc4ks_pkg::t_dp_cmd                  i_cmd,
    input  logic [rc4ks_pkg::KEY_WORD_W-1:0]    i_key_low,
    input  logic [rc4ks_pkg::KEY_WORD_W-1:0]    i_key_high,
    input  logic [rc4ks_pkg::KEY_LEN_W-1:0]     i_key_len,
    input  logic                                i_out_ready,
    output rc4ks_pkg::t_dp_sts                  o_sts,
    output logic                                o_out_valid,
    output logic [rc4ks_pkg::ROW_W-1:0]         o_out_idx,
    output logic [rc4ks_pkg::ROW_DATA_W-1:0]    o_out_data,
    output logic                                o_out_last
);

    localparam int KPW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KLW = $clog2(MAX_KEY_BYTES + 1);

    // permutation, eight entries to a row, byte writes
    logic [rc4ks_pkg::ROW_DATA_W-1:0] mem [rc4ks_pkg::ROWS];
    logic [rc4ks_pkg::ROW_DATA_W-1:0] r_rd;

    logic [rc4ks_pkg::BYTE_W-1:0]     r_key [MAX_KEY_BYTES];
    logic [KLW-1:0]                   r_len;
    logic [KPW-1:0]                   r_kp;
    logic [KPW-1:0]                   n_kp;
    logic [rc4ks_pkg::IDX_W-1:0]      r_i;
    logic [rc4ks_pkg::IDX_W-1:0]      n_i;
    logic [rc4ks_pkg::IDX_W-1:0]      r_j;
    logic [rc4ks_pkg::IDX_W-1:0]      n_j;
    logic [rc4ks_pkg::BYTE_W-1:0]     r_si;
    logic [rc4ks_pkg::ROW_W-1:0]      r_chunk;
    logic [rc4ks_pkg::ROW_W-1:0]      n_chunk;
    logic                             r_out_valid;

    logic [2*rc4ks_pkg::KEY_WORD_W-1:0] key_all;
    logic [rc4ks_pkg::KEY_LEN_W-1:0]  len_eff;
    logic [rc4ks_pkg::BYTE_W-1:0]     si;
    logic [rc4ks_pkg::BYTE_W-1:0]     sj;
    logic [rc4ks_pkg::BYTE_W-1:0]     kb;
    logic [KLW-1:0]                   kp_inc;
    logic                             rd_en;
    logic [rc4ks_pkg::ROW_W-1:0]      rd_addr;
    logic [rc4ks_pkg::LANES-1:0]      wr_en;
    logic [rc4ks_pkg::ROW_W-1:0]      wr_addr;
    logic [rc4ks_pkg::BYTE_W-1:0]     wr_val;
    logic                             wr_fill;

    assign key_all = {i_key_high, i_key_low};
    assign si      = r_rd[{r_i[rc4ks_pkg::LANE_W-1:0], 3'b000} +: rc4ks_pkg::BYTE_W];
    assign sj      = r_rd[{r_j[rc4ks_pkg::LANE_W-1:0], 3'b000} +: rc4ks_pkg::BYTE_W];
    assign kb      = r_key[r_kp];
    assign kp_inc  = KLW'(r_kp) + KLW'(1);

    always_comb begin
        if (i_key_len == '0) begin
            len_eff = rc4ks_pkg::KEY_LEN_W'(1);
        end else if (i_key_len > rc4ks_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
            len_eff = rc4ks_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
        end else begin
            len_eff = i_key_len;
        end
    end

    always_comb begin
        n_i     = r_i;
        n_j     = r_j;
        n_kp    = r_kp;
        n_chunk = r_chunk;
        rd_en   = 1'b0;
        rd_addr = r_chunk;
        wr_en   = '0;
        wr_addr = r_chunk;
        wr_val  = r_si;
        wr_fill = 1'b0;
        case (i_cmd.op)
            rc4ks_pkg::OP_LOAD: begin
                n_i     = '0;
                n_j     = '0;
                n_kp    = '0;
                n_chunk = '0;
            end
            rc4ks_pkg::OP_FILL: begin
                wr_en   = '1;
                wr_fill = 1'b1;
                n_chunk = r_chunk + 1'b1;
            end
            rc4ks_pkg::OP_RD_I: begin
                rd_en   = 1'b1;
                rd_addr = r_i[rc4ks_pkg::IDX_W-1:rc4ks_pkg::LANE_W];
            end
            rc4ks_pkg::OP_RD_J: begin
                // j += S[i] + key byte, mod 256 by width
                n_j     = r_j + si + kb;
                rd_en   = 1'b1;
                rd_addr = n_j[rc4ks_pkg::IDX_W-1:rc4ks_pkg::LANE_W];
                n_kp    = (kp_inc >= r_len) ? '0 : KPW'(r_kp + KPW'(1));
            end
            rc4ks_pkg::OP_WR_J: begin
                wr_addr = r_j[rc4ks_pkg::IDX_W-1:rc4ks_pkg::LANE_W];
                wr_en[r_j[rc4ks_pkg::LANE_W-1:0]] = 1'b1;
                wr_val  = r_si;
            end
            rc4ks_pkg::OP_WR_I: begin
                // read data still holds the row of j
                wr_addr = r_i[rc4ks_pkg::IDX_W-1:rc4ks_pkg::LANE_W];
                wr_en[r_i[rc4ks_pkg::LANE_W-1:0]] = 1'b1;
                wr_val  = sj;
                n_i     = r_i + 1'b1;
            end
            rc4ks_pkg::OP_OUT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_chunk;
            end
            rc4ks_pkg::OP_OUT_LD: begin
                n_chunk = r_chunk + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < rc4ks_pkg::LANES; l++) begin
            if (wr_en[l]) begin
                mem[wr_addr][l*rc4ks_pkg::BYTE_W +: rc4ks_pkg::BYTE_W] <=
                    wr_fill ? {r_chunk, rc4ks_pkg::LANE_W'(l)} : wr_val;
            end
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rc4ks_pkg::OP_LOAD) begin
            for (int b = 0; b < MAX_KEY_BYTES; b++) begin
                r_key[b] <= key_all[b*rc4ks_pkg::BYTE_W +: rc4ks_pkg::BYTE_W];
            end
            r_len <= KLW'(len_eff);
        end
        if (i_cmd.op == rc4ks_pkg::OP_RD_J) begin
            r_si <= si;
        end
        if (i_cmd.op == rc4ks_pkg::OP_OUT_LD) begin
            o_out_data <= r_rd;
            o_out_idx  <= r_chunk;
            o_out_last <= (r_chunk == rc4ks_pkg::ROW_W'(rc4ks_pkg::ROWS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_j         <= '0;
            r_kp        <= '0;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_i     <= n_i;
            r_j     <= n_j;
            r_kp    <= n_kp;
            r_chunk <= n_chunk;
            if (i_cmd.op == rc4ks_pkg::OP_OUT_LD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sts.chunk_last = (r_chunk == rc4ks_pkg::ROW_W'(rc4ks_pkg::ROWS - 1));
    assign o_sts.pass_last  = (r_i == '1);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

[rtl/core/rc4_key_schedule.sv]
// RC4 key schedule.
// i_key (sink): one word per key: key bytes 0..7 and 8..15, and a length.
//   A length of 0 counts as 1; above MAX_KEY_BYTES it saturates.
// o_perm (source): 32 words per key, chunk_index 0..31, each carrying eight
//   permutation entries, lowest entry in bits 7:0; last_chunk marks word 31.
// Sequence, one key at a time:
//   identity fill of all 32 rows (one 64-bit row per cycle),
//   256 swap passes (read S[i], read S[j], write S[j], write S[i])
//   on the single-port 32 x 64 permutation RAM,
//   then per output word a RAM read and a load into the output register.
//   The next key is taken only once the sequencer is back in idle after the
//   last word has been loaded.
// i_key.ready is high only while idle. The last output word may still sit in
//   the output register when the next key is taken.
// Receiver stall: the output register holds its word and the sequencer waits;
//   no word is dropped or repeated.
// Reset (synchronous, active low) returns the sequencer to idle and drops
//   o_perm.valid; the RAM contents are rewritten by every key before use.
module rc4_key_schedule #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rc4ks_key_if.sink           i_key,
    rc4ks_perm_if.source        o_perm
);

    rc4ks_pkg::t_dp_cmd cmd;
    rc4ks_pkg::t_dp_sts sts;

    // sequencer: fill, swap passes, word readout
    rc4ks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_key.valid),
        .i_sts      (sts),
        .o_in_ready (i_key.ready),
        .o_cmd      (cmd)
    );

    // permutation RAM, indexes, key register and output register
    rc4ks_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_key_low   (i_key.key_bytes_low),
        .i_key_high  (i_key.key_bytes_high),
        .i_key_len   (i_key.key_length),
        .i_out_ready (o_perm.ready),
        .o_sts       (sts),
        .o_out_valid (o_perm.valid),
        .o_out_idx   (o_perm.chunk_index),
        .o_out_data  (o_perm.perm_bytes),
        .o_out_last  (o_perm.last_chunk)
    );

endmodule

[rtl/core/rc4ks_chk.sv]
module rc4ks_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [rc4ks_pkg::ROW_W-1:0]         i_out_idx,
    input  logic [rc4ks_pkg::ROW_DATA_W-1:0]    i_out_data,
    input  logic                                i_out_last
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_data) && $stable(i_out_idx) && $stable(i_out_last))
        else $error("output word changed while stalled");

    // a taken key keeps the block busy
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("key taken while schedule running");

    // last mark only on the final chunk
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_idx == rc4ks_pkg::ROW_W'(rc4ks_pkg::ROWS - 1))))
        else $error("last_chunk and chunk_index disagree");

    // reset leaves the block idle with no word pending
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

endmodule

bind rc4_key_schedule rc4ks_chk u_rc4ks_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_key.valid),
    .i_in_ready  (i_key.ready),
    .i_out_valid (o_perm.valid),
    .i_out_ready (o_perm.ready),
    .i_out_idx   (o_perm.chunk_index),
    .i_out_data  (o_perm.perm_bytes),
    .i_out_last  (o_perm.last_chunk)
);

[bench/tb_rc4_key_schedule.sv]
module tb_rc4_key_schedule;

    localparam int MAX_KEY_BYTES = 16;
    localparam int PERM_ENTRIES  = 256;
    localparam int RANDOM_KEYS   = 330;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PRINT_CAP     = 40;

    // one key word as queued for the driver
    typedef struct {
        logic [rc4ks_pkg::KEY_WORD_W-1:0] low;
        logic [rc4ks_pkg::KEY_WORD_W-1:0] high;
        logic [rc4ks_pkg::KEY_LEN_W-1:0]  length;
        bit                               drain_first;  // hold off until all rows are back
    } t_key_word;

    // one permutation row as the block should deliver it
    typedef struct packed {
        logic [rc4ks_pkg::ROW_W-1:0]      chunk;
        logic [rc4ks_pkg::ROW_DATA_W-1:0] entries;
        logic                             last;
    } t_perm_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rc4ks_key_if  key_if ();
    rc4ks_perm_if perm_if ();

    rc4_key_schedule #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .o_perm  (perm_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_key_word pending_keys[$];
    t_perm_row perm_rows_due[$];
    t_key_word on_bus;
    int        rows_promised = 0;   // driver side, blocking
    int        rows_seen     = 0;   // monitor side, nonblocking
    int        fail_count    = 0;
    int        cycle_count   = 0;
    int        gap_left;
    int        burst_left;
    int        stall_tick;
    int        stall_mode;

    task automatic flag_mismatch(input string what,
                                 input logic [rc4ks_pkg::ROW_DATA_W-1:0] want,
                                 input logic [rc4ks_pkg::ROW_DATA_W-1:0] got);
        if (fail_count < PRINT_CAP)
            $display("mismatch at word %0d: %s expected %h got %h", rows_seen, what, want, got);
        fail_count++;
    endtask

    // Full KSA on a private permutation: identity fill, 256 swap passes,
    // then 32 rows of eight entries queued in output order.
    task automatic run_key_schedule(input t_key_word kw);
        logic [rc4ks_pkg::BYTE_W-1:0] sbox [PERM_ENTRIES];
        logic [rc4ks_pkg::BYTE_W-1:0] key_lane [2*rc4ks_pkg::LANES];
        logic [rc4ks_pkg::BYTE_W-1:0] jj;
        logic [rc4ks_pkg::BYTE_W-1:0] si;
        logic [rc4ks_pkg::BYTE_W-1:0] swap_tmp;
        int                           eff_len;
        int                           kpos;
        t_perm_row                    row;
        for (int n = 0; n < PERM_ENTRIES; n++)
            sbox[n] = rc4ks_pkg::BYTE_W'(n);
        for (int b = 0; b < rc4ks_pkg::LANES; b++) begin
            key_lane[b] = kw.low[b*rc4ks_pkg::BYTE_W +: rc4ks_pkg::BYTE_W];
            key_lane[b + rc4ks_pkg::LANES] = kw.high[b*rc4ks_pkg::BYTE_W +: rc4ks_pkg::BYTE_W];
        end
        // length 0 acts as 1, anything past the max saturates
        if (kw.length == 0)
            eff_len = 1;
        else if (kw.length > MAX_KEY_BYTES)
            eff_len = MAX_KEY_BYTES;
        else
            eff_len = int'(kw.length);
        jj   = '0;
        kpos = 0;
        for (int ii = 0; ii < PERM_ENTRIES; ii++) begin
            si           = sbox[ii];
            jj           = jj + si + key_lane[kpos];   // wraps mod 256
            swap_tmp     = sbox[jj];
            sbox[jj]     = si;
            sbox[ii]     = swap_tmp;
            kpos         = (kpos + 1 >= eff_len) ? 0 : kpos + 1;
        end
        for (int k = 0; k < rc4ks_pkg::ROWS; k++) begin
            row.chunk = rc4ks_pkg::ROW_W'(k);
            for (int b = 0; b < rc4ks_pkg::LANES; b++)
                row.entries[b*rc4ks_pkg::BYTE_W +: rc4ks_pkg::BYTE_W] =
                    sbox[k*rc4ks_pkg::LANES + b];
            row.last = (k == rc4ks_pkg::ROWS - 1);
            perm_rows_due = {perm_rows_due, row};
        end
    endtask

    task automatic queue_key(input logic [rc4ks_pkg::KEY_WORD_W-1:0] low,
                             input logic [rc4ks_pkg::KEY_WORD_W-1:0] high,
                             input logic [rc4ks_pkg::KEY_LEN_W-1:0]  length,
                             input bit drain_first);
        t_key_word kw;
        kw.low         = low;
        kw.high        = high;
        kw.length      = length;
        kw.drain_first = drain_first;
        pending_keys   = {pending_keys, kw};
    endtask

    // Driver: bursts of keys with random gaps; a flagged key waits for the
    // permutation of every earlier key to come back first.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_if.valid <= 1'b0;
            gap_left   = 0;
            burst_left = 1;
        end else begin
            if (key_if.valid && key_if.ready) begin
                run_key_schedule(on_bus);
                rows_promised += rc4ks_pkg::ROWS;
            end
            if (!key_if.valid || key_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    key_if.valid <= 1'b0;
                end else if (pending_keys.size() != 0 &&
                             !(pending_keys[0].drain_first && rows_promised != rows_seen)) begin
                    on_bus = pending_keys.pop_front();
                    key_if.valid          <= 1'b1;
                    key_if.key_bytes_low  <= on_bus.low;
                    key_if.key_bytes_high <= on_bus.high;
                    key_if.key_length     <= on_bus.length;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 6);
                        // mostly short gaps, now and then one spanning a whole key
                        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1300)
                                                               : $urandom_range(0, 5);
                    end
                end else begin
                    key_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each row word against the oldest prediction and stalls
    // in one of four modes, redrawn at random as stall_tick runs.
    always @(posedge i_clk) begin
        t_perm_row want;
        if (!i_rst_n) begin
            perm_if.ready <= 1'b0;
            stall_tick = 0;
            stall_mode = 0;
        end else begin
            if (perm_if.valid && perm_if.ready) begin
                rows_seen <= rows_seen + 1;
                if (perm_rows_due.size() == 0) begin
                    flag_mismatch("word with nothing due, chunk_index", '0,
                                  rc4ks_pkg::ROW_DATA_W'(perm_if.chunk_index));
                end else begin
                    want = perm_rows_due.pop_front();
                    if (perm_if.chunk_index !== want.chunk)
                        flag_mismatch("chunk_index", rc4ks_pkg::ROW_DATA_W'(want.chunk),
                                      rc4ks_pkg::ROW_DATA_W'(perm_if.chunk_index));
                    if (perm_if.perm_bytes !== want.entries)
                        flag_mismatch("perm_bytes", want.entries, perm_if.perm_bytes);
                    if (perm_if.last_chunk !== want.last)
                        flag_mismatch("last_chunk", rc4ks_pkg::ROW_DATA_W'(want.last),
                                      rc4ks_pkg::ROW_DATA_W'(perm_if.last_chunk));
                end
            end
            stall_tick++;
            if (stall_tick % 256 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       perm_if.ready <= 1'b1;
                1:       perm_if.ready <= ($urandom_range(0, 1) != 0);
                2:       perm_if.ready <= (stall_tick % 5 >= 3);
                default: perm_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still due", cycle_count,
                     perm_rows_due.size());
            $display("tb_rc4_key_schedule NOT OK");
            $finish;
        end
    end

    initial begin
        logic [rc4ks_pkg::KEY_LEN_W-1:0] rand_len;
        i_rst_n               = 1'b0;
        key_if.valid          = 1'b0;
        key_if.key_bytes_low  = '0;
        key_if.key_bytes_high = '0;
        key_if.key_length     = '0;
        perm_if.ready         = 1'b0;

        // directed: field extremes, zero length, oversize length, ignored tail bytes
        queue_key('0, '0, 5'd1, 1'b0);
        queue_key('1, '1, 5'd0, 1'b0);
        queue_key('1, '1, 5'd16, 1'b0);
        queue_key('0, '0, 5'd16, 1'b0);
        queue_key(64'h0807060504030201, 64'h100f0e0d0c0b0a09, 5'd16, 1'b0);
        queue_key({8{8'haa}}, {8{8'h55}}, 5'd16, 1'b0);
        queue_key({8{8'h55}}, {8{8'haa}}, 5'd31, 1'b0);
        queue_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd17, 1'b0);
        queue_key(64'hffff_ffff_ffff_ff80, '1, 5'd1, 1'b0);
        queue_key('1, '0, 5'd8, 1'b0);
        queue_key(64'h0101010101010101, {$urandom, $urandom}, 5'd9, 1'b0);
        queue_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd15, 1'b0);
        // same key around another one: nothing may carry between keys
        queue_key(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd5, 1'b0);
        queue_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd2, 1'b0);
        queue_key(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd5, 1'b0);
        queue_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b1);

        for (int n = 0; n < RANDOM_KEYS; n++) begin
            if ($urandom_range(0, 15) == 0)
                rand_len = $urandom_range(0, 1) ? 5'd0
                                                : rc4ks_pkg::KEY_LEN_W'($urandom_range(17, 31));
            else
                rand_len = rc4ks_pkg::KEY_LEN_W'($urandom_range(1, MAX_KEY_BYTES));
            queue_key({$urandom, $urandom}, {$urandom, $urandom}, rand_len,
                      $urandom_range(0, 24) == 0);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample on the falling edge so every update of the edge has landed
        do
            @(negedge i_clk);
        while (pending_keys.size() != 0 || key_if.valid || rows_promised != rows_seen);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_rc4_key_schedule OK");
        else
            $display("tb_rc4_key_schedule NOT OK");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rc4ks_pkg.sv
rtl/core/rc4ks_if.sv
rtl/core/rc4ks_ctrl.sv
rtl/core/rc4ks_dp.sv
rtl/core/rc4_key_schedule.sv
rtl/core/rc4ks_chk.sv
bench/tb_rc4_key_schedule.sv
